FILE: hw/rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

  localparam int NUM_STAGES = 7;

  // Q4.8 unit and the hue scale in 1/16 degree.
  localparam logic [8:0]  UNIT_ONE   = 9'd256;
  localparam logic [9:0]  HUE_SECTOR = 10'd960;
  localparam logic [6:0]  SECTORS    = 7'd6;

  // Six full turns lift any 16-bit hue into positive range before the wrap.
  localparam logic [16:0] HUE_BIAS   = 17'd34560;

  // Reciprocals: (y * 4370) >> 16 is floor(y / 15) for y below 4096,
  // and (q * 43) >> 8 is floor(q / 6) for q up to 70.
  localparam logic [12:0] RECIP_15   = 13'd4370;
  localparam logic [5:0]  RECIP_6    = 6'd43;

  // One in the fraction scale: 256 (saturation) times 960 (hue sector).
  localparam logic [17:0] FRAC_ONE   = 18'd245760;

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_RED     = 3'd0;
  localparam sector_t SEC_YELLOW  = 3'd1;
  localparam sector_t SEC_GREEN   = 3'd2;
  localparam sector_t SEC_CYAN    = 3'd3;
  localparam sector_t SEC_BLUE    = 3'd4;
  localparam sector_t SEC_MAGENTA = 3'd5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

  function automatic logic [8:0] clamp_unit(input logic signed [11:0] x);
    logic [8:0] res;
    if (x[11]) begin
      res = '0;
    end else if (x > 12'sd256) begin
      res = UNIT_ONE;
    end else begin
      res = x[8:0];
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/hsvrgb_ctrl.sv
module hsvrgb_ctrl
  import hsvrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  output logic       in_stall,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or when the stage after it moves on,
  // so bubbles close up while the receiver stalls.
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall = !en[0];
  assign ctrl.en  = en;
  assign ctrl.vld = vld_r;

endmodule

FILE: hw/rtl/hsvrgb_hue.sv
module hsvrgb_hue
  import hsvrgb_pkg::*;
(
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  logic signed [15:0] in_hue,
  input  logic signed [11:0] in_saturation,
  input  logic signed [11:0] in_brightness,
  input  logic               in_hue_invalid,
  output logic [9:0]         hue_frac,
  output logic [6:0]         hue_quo,
  output logic [3:0]         hue_quo6,
  output logic [8:0]         hue_sat,
  output logic [8:0]         hue_val,
  output logic               hue_inv
);

  // Stage 1: clamp and bias.
  logic [16:0] s1_x_r;
  logic [8:0]  s1_s_r, s1_v_r;
  logic        s1_inv_r;

  // Stage 2: quotient by the sector width.
  logic [16:0] s2_x_r;
  logic [6:0]  s2_q_r;
  logic [8:0]  s2_s_r, s2_v_r;
  logic        s2_inv_r;

  // Stage 3: fraction within the sector and quotient by six.
  logic [9:0]  s3_f_r;
  logic [6:0]  s3_q_r;
  logic [3:0]  s3_d_r;
  logic [8:0]  s3_s_r, s3_v_r;
  logic        s3_inv_r;

  logic [23:0] y_prod;
  logic [16:0] q960;
  logic [16:0] frac_full;
  logic [11:0] q43;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      s1_x_r   <= {in_hue[15], in_hue} + HUE_BIAS;
      s1_s_r   <= clamp_unit(in_saturation);
      s1_v_r   <= clamp_unit(in_brightness);
      s1_inv_r <= in_hue_invalid;
    end
  end

  // 960 is 64 * 15: drop six bits, then divide by fifteen.
  assign y_prod = {13'd0, s1_x_r[16:6]} * {11'd0, RECIP_15};

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      s2_x_r   <= s1_x_r;
      s2_q_r   <= y_prod[22:16];
      s2_s_r   <= s1_s_r;
      s2_v_r   <= s1_v_r;
      s2_inv_r <= s1_inv_r;
    end
  end

  assign q960      = {10'd0, s2_q_r} * {7'd0, HUE_SECTOR};
  assign frac_full = s2_x_r - q960;
  assign q43       = {5'd0, s2_q_r} * {6'd0, RECIP_6};

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      s3_f_r   <= frac_full[9:0];
      s3_q_r   <= s2_q_r;
      s3_d_r   <= q43[11:8];
      s3_s_r   <= s2_s_r;
      s3_v_r   <= s2_v_r;
      s3_inv_r <= s2_inv_r;
    end
  end

  assign hue_frac = s3_f_r;
  assign hue_quo  = s3_q_r;
  assign hue_quo6 = s3_d_r;
  assign hue_sat  = s3_s_r;
  assign hue_val  = s3_v_r;
  assign hue_inv  = s3_inv_r;

endmodule

FILE: hw/rtl/hsvrgb_chan.sv
module hsvrgb_chan
  import hsvrgb_pkg::*;
(
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  logic [9:0] hue_frac,
  input  logic [6:0] hue_quo,
  input  logic [3:0] hue_quo6,
  input  logic [8:0] hue_sat,
  input  logic [8:0] hue_val,
  input  logic       hue_inv,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  // Stage 4: sector, s*f, s*(1-f) and v*(1-s).
  sector_t     s4_sector_r;
  logic [17:0] s4_wq_r, s4_wt_r;
  logic [16:0] s4_pprod_r;
  logic [8:0]  s4_v_r;
  logic        s4_inv_r;

  // Stage 5: v*(1-s*f) and v*(1-s*(1-f)), finished p and v channels.
  sector_t     s5_sector_r;
  logic [25:0] s5_xq_r, s5_xt_r;
  logic [7:0]  s5_cp_r, s5_cv_r;
  logic        s5_inv_r;

  // Stage 6: scaled by 255 and divided by 2^22.
  sector_t     s6_sector_r;
  logic [11:0] s6_yq_r, s6_yt_r;
  logic [7:0]  s6_cp_r, s6_cv_r;
  logic        s6_inv_r;

  // Stage 7: output registers.
  logic [7:0]  red_r, green_r, blue_r;

  logic [6:0]  d6;
  logic [6:0]  sec_diff;
  logic [9:0]  frac_rest;
  logic [17:0] numq, numt;
  logic [24:0] p255;
  logic [16:0] v255;
  logic [33:0] xq255, xt255;
  logic [24:0] cq_prod, ct_prod;
  logic [7:0]  cq, ct;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;

  assign d6        = {3'd0, hue_quo6} * SECTORS;
  assign sec_diff  = hue_quo - d6;
  assign frac_rest = HUE_SECTOR - hue_frac;

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      s4_sector_r <= sec_diff[2:0];
      s4_wq_r     <= {9'd0, hue_sat} * {8'd0, hue_frac};
      s4_wt_r     <= {9'd0, hue_sat} * {8'd0, frac_rest};
      s4_pprod_r  <= {8'd0, hue_val} * {8'd0, UNIT_ONE - hue_sat};
      s4_v_r      <= hue_val;
      s4_inv_r    <= hue_inv;
    end
  end

  assign numq = FRAC_ONE - s4_wq_r;
  assign numt = FRAC_ONE - s4_wt_r;
  assign p255 = {s4_pprod_r, 8'd0} - {8'd0, s4_pprod_r};
  assign v255 = {s4_v_r, 8'd0} - {8'd0, s4_v_r};

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      s5_sector_r <= s4_sector_r;
      s5_xq_r     <= {17'd0, s4_v_r} * {8'd0, numq};
      s5_xt_r     <= {17'd0, s4_v_r} * {8'd0, numt};
      s5_cp_r     <= p255[23:16];
      s5_cv_r     <= v255[15:8];
      s5_inv_r    <= s4_inv_r;
    end
  end

  // Dividing by 256 * 245760 is a shift by 22 followed by a divide by 15.
  assign xq255 = {s5_xq_r, 8'd0} - {8'd0, s5_xq_r};
  assign xt255 = {s5_xt_r, 8'd0} - {8'd0, s5_xt_r};

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      s6_sector_r <= s5_sector_r;
      s6_yq_r     <= xq255[33:22];
      s6_yt_r     <= xt255[33:22];
      s6_cp_r     <= s5_cp_r;
      s6_cv_r     <= s5_cv_r;
      s6_inv_r    <= s5_inv_r;
    end
  end

  assign cq_prod = {13'd0, s6_yq_r} * {12'd0, RECIP_15};
  assign ct_prod = {13'd0, s6_yt_r} * {12'd0, RECIP_15};
  assign cq      = cq_prod[23:16];
  assign ct      = ct_prod[23:16];

  always_comb begin
    if (s6_inv_r) begin
      red_nxt   = s6_cv_r;
      green_nxt = s6_cv_r;
      blue_nxt  = s6_cv_r;
    end else begin
      unique case (s6_sector_r)
        SEC_RED: begin
          red_nxt = s6_cv_r; green_nxt = ct;      blue_nxt = s6_cp_r;
        end
        SEC_YELLOW: begin
          red_nxt = cq;      green_nxt = s6_cv_r; blue_nxt = s6_cp_r;
        end
        SEC_GREEN: begin
          red_nxt = s6_cp_r; green_nxt = s6_cv_r; blue_nxt = ct;
        end
        SEC_CYAN: begin
          red_nxt = s6_cp_r; green_nxt = cq;      blue_nxt = s6_cv_r;
        end
        SEC_BLUE: begin
          red_nxt = ct;      green_nxt = s6_cp_r; blue_nxt = s6_cv_r;
        end
        default: begin
          red_nxt = s6_cv_r; green_nxt = s6_cp_r; blue_nxt = cq;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[6]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

FILE: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter for a pixel stream.
//
// Input channel (in_*): a hue in 1/16 degree, wrapped into one turn, and
// saturation and value in signed Q4.8, clamped to 0..1.0. When
// in_hue_invalid is set, the pixel comes out grey at the value level.
// Output channel (out_*): 8-bit red, green and blue, each floor(x * 255).
// A beat moves on a channel at a clock edge where valid is high and stall
// is low.
//
// The datapath is a seven-stage pipeline: a beat accepted into the first
// stage passes through each stage register in order to the output
// registers, and one beat is taken every cycle while out_stall is low.
// The stages are bounded by the reciprocal multiplies and the 34-bit
// scale by 255 ahead of the final divide by fifteen.
// A stall from the receiver holds the last stage; earlier stages keep
// filling empty slots, and in_stall rises only once the beat in the first
// stage has nowhere to go. Synchronous reset empties the pipeline; the
// data registers are not cleared.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_hue,
  input  logic signed [11:0] in_saturation,
  input  logic signed [11:0] in_brightness,
  input  logic               in_hue_invalid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  pipe_ctrl_t ctrl;
  logic [9:0] hue_frac;
  logic [6:0] hue_quo;
  logic [3:0] hue_quo6;
  logic [8:0] hue_sat;
  logic [8:0] hue_val;
  logic       hue_inv;

  hsvrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  hsvrgb_hue u_hue (
    .clk            (clk),
    .ctrl           (ctrl),
    .in_hue         (in_hue),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .in_hue_invalid (in_hue_invalid),
    .hue_frac       (hue_frac),
    .hue_quo        (hue_quo),
    .hue_quo6       (hue_quo6),
    .hue_sat        (hue_sat),
    .hue_val        (hue_val),
    .hue_inv        (hue_inv)
  );

  hsvrgb_chan u_chan (
    .clk      (clk),
    .ctrl     (ctrl),
    .hue_frac (hue_frac),
    .hue_quo  (hue_quo),
    .hue_quo6 (hue_quo6),
    .hue_sat  (hue_sat),
    .hue_val  (hue_val),
    .hue_inv  (hue_inv),
    .red      (out_red),
    .green    (out_green),
    .blue     (out_blue)
  );

  assign out_valid = ctrl.vld[NUM_STAGES-1];

`ifndef SYNTHESIS
  // With the receiver taking beats, every stage advances and the input
  // is never held off.
  a_no_stall_without_backpressure: assert property (
    @(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall
  ) else $error("input stalled while the output drains freely");

  // The reciprocal divide must leave a fraction inside one sector.
  a_frac_in_sector: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctrl.vld[2] |-> (hue_frac < HUE_SECTOR)
  ) else $error("hue fraction outside the sector width");

  // The quotient by six must leave a sector number from zero to five.
  a_sector_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctrl.vld[2] |-> (({3'd0, hue_quo6} * SECTORS) <= hue_quo) &&
                    ((hue_quo - {3'd0, hue_quo6} * SECTORS) < SECTORS)
  ) else $error("sector number out of range");
`endif

endmodule
